/* sv/sitf_pkg.sv */
// ----------------------------------------------------------------------------
// sitf_pkg: shared types and constants of the sorted ID table
// Field widths, stream packing, opcodes, status codes and cell interfaces.
// ----------------------------------------------------------------------------
package sitf_pkg;

  localparam int DEF_MAX_ENTRIES = 64;

  localparam int ID_W     = 32;
  localparam int RIDX_W   = 6;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int ECNT_W   = 7;

  // Request stream: tdata = {pad, read_index, lookup_id}, tuser = opcode.
  localparam int S_DATA_W = 40;
  localparam int S_USER_W = 1;

  // Response stream: tdata = {pad, max_id, min_id, entry_count, id_out,
  // position}, tuser = status.
  localparam int M_DATA_W = 112;
  localparam int M_USER_W = STATUS_W;

  localparam logic OP_FIND = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_INSERTED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_RANGE    = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  // Controls into one cell of the row.
  typedef struct packed {
    logic prev_lt;  // left neighbor holds an ID below the key
    logic valid;    // cell index is below the entry count
    logic shift;    // insert step is committed this cycle
    logic rd_sel;   // cell is addressed by a read request
  } cell_ctl_t;

  // Flags out of one cell.
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flag_t;

endpackage

/* sv/sitf_cell.sv */
// ----------------------------------------------------------------------------
// sitf_cell: one slot of the sorted ID row
// Holds one ID, compares it against the key and takes the key or its left
// neighbor's ID when an insert moves the upper part of the row up by one.
// ----------------------------------------------------------------------------
module sitf_cell (
  input  logic                       clk,
  input  logic [sitf_pkg::ID_W-1:0]  key,
  input  logic [sitf_pkg::ID_W-1:0]  prev_id,
  input  sitf_pkg::cell_ctl_t        ctl,
  output logic [sitf_pkg::ID_W-1:0]  id,
  output logic [sitf_pkg::ID_W-1:0]  rd_data,
  output sitf_pkg::cell_flag_t       flag
);
  import sitf_pkg::*;

  always_comb begin
    flag.lt = ctl.valid && (id < key);
    flag.eq = ctl.valid && (id == key);
    rd_data = ctl.rd_sel ? id : '0;
  end

  // Cells below the insert point keep their ID; the first cell at or above
  // it takes the key and every later one takes its neighbor's ID.
  always_ff @(posedge clk) begin
    if (ctl.shift && !flag.lt) begin
      id <= ctl.prev_lt ? key : prev_id;
    end
  end

endmodule

/* sv/sitf_enc.sv */
// ----------------------------------------------------------------------------
// sitf_enc: one-hot to binary encoder
// Turns the single marked cell of the row into its index.
// ----------------------------------------------------------------------------
module sitf_enc #(
  parameter int N  = 64,
  parameter int IW = 6
) (
  input  logic [N-1:0]  onehot,
  output logic [IW-1:0] idx
);

  always_comb begin
    idx = '0;
    for (int i = 0; i < N; i++) begin
      if (onehot[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

endmodule

/* sv/sorted_id_table_find_or_insert_core.sv */
// ----------------------------------------------------------------------------
// sorted_id_table_find_or_insert_core: sorted ID table with find-or-insert
// Keeps up to MAX_ENTRIES distinct IDs in ascending order in a row of cells.
// ----------------------------------------------------------------------------
// Each request is first registered and then handled in the execute state, in
// which every cell of the row compares its ID against the key in parallel, the
// insert point is encoded, and on an insert the cells at and above that point
// shift up by one in the same edge. The result then sits in an output register
// while the next request is already taken in; a stalled response holds the
// row back only in its compare cycle. A find-or-insert request returns the
// sorted position of the ID and inserts it if absent (status 1), flags a full
// table with status 2 and leaves it unchanged; a read returns the ID at a
// sorted index, or status 3 when the index is not below the entry count.
// Every response carries the count, minimum and maximum after the request.
module sorted_id_table_find_or_insert_core #(
  parameter int MAX_ENTRIES = sitf_pkg::DEF_MAX_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // lookup_id[31:0], read_index[37:32], zero pad [39:38]
  input  logic [sitf_pkg::S_DATA_W-1:0] s_tdata,
  // opcode[0]
  input  logic [sitf_pkg::S_USER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // position[5:0], id_out[37:6], entry_count[44:38], min_id[76:45],
  // max_id[108:77], zero pad [111:109]
  output logic [sitf_pkg::M_DATA_W-1:0] m_tdata,
  // status[1:0]
  output logic [sitf_pkg::M_USER_W-1:0] m_tuser
);
  import sitf_pkg::*;

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int XW = (CW > RIDX_W) ? CW : RIDX_W;

  state_t state;

  logic                op;
  logic [ID_W-1:0]     key;
  logic [RIDX_W-1:0]   ridx;

  logic [CW-1:0]       count;
  logic [ID_W-1:0]     smallest;
  logic [ID_W-1:0]     largest;

  logic [CW-1:0]       count_next;
  logic [ID_W-1:0]     smallest_next;
  logic [ID_W-1:0]     largest_next;

  logic [ID_W-1:0]     cell_id   [MAX_ENTRIES];
  logic [ID_W-1:0]     cell_rd   [MAX_ENTRIES];
  cell_flag_t          cell_flag [MAX_ENTRIES];
  cell_ctl_t           cell_ctl  [MAX_ENTRIES];

  logic [MAX_ENTRIES-1:0] edge_vec;
  logic [MAX_ENTRIES-1:0] eq_vec;
  logic [IW-1:0]          ins_pos;
  logic [ID_W-1:0]        rd_word;

  logic go;
  logic found;
  logic full;
  logic ins;
  logic read_ok;

  logic [STATUS_W-1:0] res_status;
  logic [POS_W-1:0]    res_pos;
  logic [ID_W-1:0]     res_id;

  assign s_tready = (state == ST_IDLE);
  assign go       = (state == ST_EXEC) && (!m_tvalid || m_tready);

  // Row of cells, each handing its ID to the next one up.
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    always_comb begin
      cell_ctl[i].prev_lt = (i == 0) ? 1'b1 : cell_flag[(i == 0) ? 0 : i-1].lt;
      cell_ctl[i].valid   = (count > CW'(i));
      cell_ctl[i].shift   = go && ins;
      if (i < (1 << RIDX_W)) begin
        cell_ctl[i].rd_sel = (XW'(ridx) == XW'(i));
      end else begin
        cell_ctl[i].rd_sel = 1'b0;
      end
      edge_vec[i] = cell_ctl[i].prev_lt && !cell_flag[i].lt;
      eq_vec[i]   = cell_flag[i].eq;
    end

    sitf_cell u_cell (
      .clk     (clk),
      .key     (key),
      .prev_id ((i == 0) ? key : cell_id[(i == 0) ? 0 : i-1]),
      .ctl     (cell_ctl[i]),
      .id      (cell_id[i]),
      .rd_data (cell_rd[i]),
      .flag    (cell_flag[i])
    );
  end

  sitf_enc #(
    .N  (MAX_ENTRIES),
    .IW (IW)
  ) u_enc (
    .onehot (edge_vec),
    .idx    (ins_pos)
  );

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  always_comb begin
    found   = |eq_vec;
    full    = (count == CW'(MAX_ENTRIES));
    ins     = (op == OP_FIND) && !found && !full;
    read_ok = (XW'(ridx) < XW'(count));

    count_next    = count;
    smallest_next = smallest;
    largest_next  = largest;
    if (ins) begin
      count_next = count + CW'(1);
      if (count == '0) begin
        smallest_next = key;
        largest_next  = key;
      end else begin
        if (key < smallest) smallest_next = key;
        if (key > largest)  largest_next  = key;
      end
    end

    if (op == OP_READ) begin
      res_pos = ridx;
      if (read_ok) begin
        res_status = STAT_OK;
        res_id     = rd_word;
      end else begin
        res_status = STAT_RANGE;
        res_id     = '0;
      end
    end else if (found) begin
      res_status = STAT_OK;
      res_pos    = POS_W'(ins_pos);
      res_id     = key;
    end else if (full) begin
      res_status = STAT_FULL;
      res_pos    = '0;
      res_id     = '0;
    end else begin
      res_status = STAT_INSERTED;
      res_pos    = POS_W'(ins_pos);
      res_id     = key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      smallest <= '0;
      largest  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (go) begin
            state    <= ST_IDLE;
            count    <= count_next;
            smallest <= smallest_next;
            largest  <= largest_next;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Request and response payload registers.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op   <= s_tuser[0];
      key  <= s_tdata[ID_W-1:0];
      ridx <= s_tdata[ID_W +: RIDX_W];
    end
    if (go) begin
      m_tuser <= res_status;
      m_tdata <= {3'b000, largest_next, smallest_next, ECNT_W'(count_next),
                  res_id, res_pos};
    end
  end

endmodule

/* bench/sorted_id_table_checker.sv */
// ----------------------------------------------------------------------------
// sorted_id_table_checker: response checker for the sorted ID table
// Watches both streams, keeps its own copy of the table, predicts the
// response of every accepted request and compares it with what comes out.
// ----------------------------------------------------------------------------
module sorted_id_table_checker #(
  parameter int MAX_ENTRIES = sitf_pkg::DEF_MAX_ENTRIES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  // lookup_id[31:0], read_index[37:32], zero pad [39:38]
  input  logic [sitf_pkg::S_DATA_W-1:0] s_tdata,
  // opcode[0]
  input  logic [sitf_pkg::S_USER_W-1:0] s_tuser,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  // position[5:0], id_out[37:6], entry_count[44:38], min_id[76:45],
  // max_id[108:77], zero pad [111:109]
  input  logic [sitf_pkg::M_DATA_W-1:0] m_tdata,
  // status[1:0]
  input  logic [sitf_pkg::M_USER_W-1:0] m_tuser,
  output int                            fail_count,
  output int                            pending
);
  import sitf_pkg::*;

  localparam int ID_LSB  = POS_W;
  localparam int CNT_LSB = ID_LSB + ID_W;
  localparam int MIN_LSB = CNT_LSB + ECNT_W;
  localparam int MAX_LSB = MIN_LSB + ID_W;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [ID_W-1:0]     id_out;
    logic [ECNT_W-1:0]   entry_count;
    logic [ID_W-1:0]     min_id;
    logic [ID_W-1:0]     max_id;
  } table_reply_t;

  logic [ID_W-1:0] held_ids [MAX_ENTRIES];
  int              held_count;
  logic [ID_W-1:0] lowest;
  logic [ID_W-1:0] highest;
  table_reply_t    expected_replies[$];

  // Applies one request to the table copy and queues the response it causes.
  task automatic apply_request(input logic op, input logic [ID_W-1:0] key,
                               input logic [RIDX_W-1:0] idx);
    table_reply_t r;
    int           slot;
    r = '0;
    if (op == OP_READ) begin
      r.position = idx;
      if (idx < held_count && idx < MAX_ENTRIES) begin
        r.status = STAT_OK;
        r.id_out = held_ids[idx];
      end else begin
        r.status = STAT_RANGE;
      end
    end else begin
      // The insert point is the first slot whose ID is not below the key.
      slot = 0;
      while (slot < held_count && held_ids[slot] < key) slot++;
      if (slot < held_count && held_ids[slot] == key) begin
        r.status   = STAT_OK;
        r.position = slot[POS_W-1:0];
        r.id_out   = key;
      end else if (held_count >= MAX_ENTRIES) begin
        r.status = STAT_FULL;
      end else begin
        for (int i = held_count; i > slot; i--) held_ids[i] = held_ids[i-1];
        held_ids[slot] = key;
        if (held_count == 0) begin
          lowest  = key;
          highest = key;
        end else begin
          if (key < lowest) lowest = key;
          if (key > highest) highest = key;
        end
        held_count++;
        r.status   = STAT_INSERTED;
        r.position = slot[POS_W-1:0];
        r.id_out   = key;
      end
    end
    r.entry_count = held_count[ECNT_W-1:0];
    r.min_id      = lowest;
    r.max_id      = highest;
    expected_replies.push_back(r);
  endtask

  always @(posedge clk) begin
    table_reply_t got;
    table_reply_t want;
    if (rst) begin
      held_count = 0;
      lowest     = '0;
      highest    = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) held_ids[i] = '0;
      expected_replies.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got.status      = m_tuser[STATUS_W-1:0];
        got.position    = m_tdata[POS_W-1:0];
        got.id_out      = m_tdata[ID_LSB +: ID_W];
        got.entry_count = m_tdata[CNT_LSB +: ECNT_W];
        got.min_id      = m_tdata[MIN_LSB +: ID_W];
        got.max_id      = m_tdata[MAX_LSB +: ID_W];
        if (expected_replies.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: response with no request waiting: st=%0d pos=%0d id=%h",
                     $realtime, got.status, got.position, got.id_out);
        end else begin
          want = expected_replies.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: response mismatch", $realtime);
              $display("  expected st=%0d pos=%0d id=%h cnt=%0d min=%h max=%h",
                       want.status, want.position, want.id_out, want.entry_count,
                       want.min_id, want.max_id);
              $display("  actual   st=%0d pos=%0d id=%h cnt=%0d min=%h max=%h",
                       got.status, got.position, got.id_out, got.entry_count,
                       got.min_id, got.max_id);
            end
          end
        end
      end
      if (s_tvalid && s_tready)
        apply_request(s_tuser[0], s_tdata[ID_W-1:0], s_tdata[ID_W +: RIDX_W]);
    end
    pending = expected_replies.size();
  end

endmodule

/* bench/sorted_id_table_find_or_insert_core_test.sv */
// ----------------------------------------------------------------------------
// sorted_id_table_find_or_insert_core_test: testbench of the sorted ID table
// Drives find-or-insert and read requests with random gaps and back-pressure,
// grows the table from empty to full and keeps working on it once full; the
// checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module sorted_id_table_find_or_insert_core_test;
  import sitf_pkg::*;

  localparam int RANDOM_ITEMS = 1500;
  localparam int PAD_W        = S_DATA_W - ID_W - RIDX_W;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic [S_USER_W-1:0] s_tuser;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [M_USER_W-1:0] m_tuser;
  int                  fail_count;
  int                  pending;
  logic                no_idle;
  logic [ID_W-1:0]     issued_ids[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sorted_id_table_find_or_insert_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  sorted_id_table_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always @(negedge clk) m_tready <= no_idle || ($urandom_range(0, 99) >= 9);

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue_request(input logic op, input logic [ID_W-1:0] key,
                               input logic [RIDX_W-1:0] idx);
    while (!no_idle && $urandom_range(0, 99) < 9) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {{PAD_W{1'b0}}, idx, key};
    if (op == OP_FIND) issued_ids.push_back(key);
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Partly small clustered IDs and edge values so that neighbors and repeats are common.
  function automatic logic [ID_W-1:0] fresh_id();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return 32'd1;
          2: return 32'hFFFF_FFFE;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2, 3: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [ID_W-1:0] key;
    int              roll;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = OP_FIND;
    no_idle  = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reads of an empty table, inserts at the ends and in the middle, then reads and a repeat.
    issue_request(OP_READ, $urandom, 6'd0);
    issue_request(OP_READ, $urandom, 6'd63);
    issue_request(OP_FIND, 32'h8000_0000, 6'd63);
    issue_request(OP_FIND, 32'h0000_0000, 6'd0);
    issue_request(OP_FIND, 32'hFFFF_FFFF, 6'd21);
    issue_request(OP_FIND, 32'h0000_0000, 6'd42);
    issue_request(OP_FIND, 32'hFFFF_FFFF, 6'd0);
    issue_request(OP_FIND, 32'h7FFF_FFFF, 6'd0);
    issue_request(OP_FIND, 32'h8000_0001, 6'd63);
    for (int i = 0; i < 5; i++) issue_request(OP_READ, $urandom, i[RIDX_W-1:0]);
    issue_request(OP_READ, 32'hFFFF_FFFF, 6'd5);
    issue_request(OP_READ, 32'h0000_0000, 6'd63);
    issue_request(OP_FIND, 32'h8000_0000, 6'd0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle <= (n >= 700 && n < 1000);
      // A sweep of spread-out IDs makes sure the table fills up.
      if (n == 300) begin
        for (int k = 0; k < 64; k++)
          issue_request(OP_FIND, (k * 32'h0400_0000) + 32'h0123_4567,
                        RIDX_W'($urandom));
        issue_request(OP_FIND, 32'h0000_0100, RIDX_W'($urandom));
      end
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        issue_request(OP_READ, $urandom, RIDX_W'($urandom_range(0, 63)));
      end else if (roll < 65) begin
        key = issued_ids[$urandom_range(0, issued_ids.size() - 1)];
        issue_request(OP_FIND, key, RIDX_W'($urandom));
      end else begin
        issue_request(OP_FIND, fresh_id(), RIDX_W'($urandom));
      end
    end
    s_tvalid <= 1'b0;
    no_idle  <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
